/* src/ebgc_pkg.sv */
// Shared types, constants and helper functions for the EMG band-pass gap counter.
package ebgc_pkg;

  localparam int NCH_MAX   = 8;
  localparam int CHANNELS  = 8;
  localparam int FRAC_BITS = 16;

  localparam int RAW_W = 12;
  localparam int SEQ_W = 8;
  localparam int GAP_W = 32;
  localparam int OUT_W = 20;

  // Action codes of an input transaction.
  localparam logic ACT_ROW     = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  // Filter mode register codes.
  localparam logic MODE_RAW    = 1'b0;
  localparam logic MODE_FILTER = 1'b1;

  // Centering: volts = round(raw * 33 * 2^FRAC_BITS / 40950).
  localparam int SCALE_NUM = 33;
  localparam int DIV_DEN   = 40950;
  localparam int DIV_HALF  = 20475;
  localparam int EST_SHIFT = 16;
  localparam int EST_W     = FRAC_BITS + 3;
  localparam int CFIX_W    = FRAC_BITS + 7;
  localparam int EST_PROD_W = RAW_W + CFIX_W;
  localparam int NUM_W     = FRAC_BITS + 20;
  localparam longint unsigned CFIX_L =
    (64'(SCALE_NUM) << (FRAC_BITS + EST_SHIFT)) / 64'(DIV_DEN);
  localparam logic [CFIX_W-1:0] CFIX = CFIX_W'(CFIX_L);
  localparam longint MID_L = (165 * (64'd1 << FRAC_BITS) + 50) / 100;
  localparam logic signed [EST_W:0] MID_S = (EST_W + 1)'(MID_L);

  // Filter coefficients in Q0.16, held as positive signed values.
  localparam logic signed [16:0] HP_ALPHA_S = 17'sd61664;
  localparam logic signed [16:0] LP_ALPHA_S = 17'sd49283;
  localparam logic signed [16:0] LP_BETA_S  = 17'sd16253;
  localparam int RND_HALF = 32768;
  localparam int COEF_SHIFT = 16;

  localparam int SAT_IN_W = 48;
  localparam logic signed [SAT_IN_W-1:0] SAT_MAX_W = 48'sd524287;
  localparam logic signed [SAT_IN_W-1:0] SAT_MIN_W = -48'sd524288;

  typedef struct packed {
    logic             action;
    logic             packet_first;
    logic [SEQ_W-1:0] seq_num;
    logic [RAW_W-1:0] ch0;
    logic [RAW_W-1:0] ch1;
    logic [RAW_W-1:0] ch2;
    logic [RAW_W-1:0] ch3;
    logic [RAW_W-1:0] ch4;
    logic [RAW_W-1:0] ch5;
    logic [RAW_W-1:0] ch6;
    logic [RAW_W-1:0] ch7;
  } sample_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out0;
    logic signed [OUT_W-1:0] out1;
    logic signed [OUT_W-1:0] out2;
    logic signed [OUT_W-1:0] out3;
    logic signed [OUT_W-1:0] out4;
    logic signed [OUT_W-1:0] out5;
    logic signed [OUT_W-1:0] out6;
    logic signed [OUT_W-1:0] out7;
    logic [GAP_W-1:0]        gap_total;
  } result_t;

  typedef struct packed {
    logic restart;
    logic start;
    logic filt;
    logic step_ctr;
    logic step_hp;
    logic step_lp;
  } lane_ctl_t;

  typedef struct packed {
    logic             restart;
    logic             row;
    logic             packet_first;
    logic [SEQ_W-1:0] seq_num;
  } seq_ctl_t;

  function automatic logic signed [OUT_W-1:0] sat20(input logic signed [SAT_IN_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > SAT_MAX_W) begin
      r = SAT_MAX_W[OUT_W-1:0];
    end else if (v < SAT_MIN_W) begin
      r = SAT_MIN_W[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

/* src/ebgc_seq.sv */
// Packet sequence tracker that accumulates missed packets from sequence gaps.
module ebgc_seq (
  input  logic                     clk,
  input  logic                     rst,
  input  ebgc_pkg::seq_ctl_t       ctl,
  output logic [ebgc_pkg::GAP_W-1:0] gap_count
);
  import ebgc_pkg::*;

  logic [SEQ_W-1:0] last_seq;
  logic             seq_seeded;
  logic [SEQ_W-1:0] gap_step;

  // The modulo-256 distance is zero when the number is the expected one.
  assign gap_step = ctl.seq_num - last_seq - SEQ_W'(1);

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      last_seq   <= '0;
      seq_seeded <= 1'b0;
      gap_count  <= '0;
    end else if (ctl.row && ctl.packet_first) begin
      if (seq_seeded) begin
        gap_count <= gap_count + GAP_W'(gap_step);
      end
      last_seq   <= ctl.seq_num;
      seq_seeded <= 1'b1;
    end
  end

endmodule

/* src/ebgc_lane.sv */
// One channel lane: centering to volts, high-pass and low-pass with its own state.
module ebgc_lane (
  input  logic                              clk,
  input  logic                              rst,
  input  ebgc_pkg::lane_ctl_t               ctl,
  input  logic [ebgc_pkg::RAW_W-1:0]        raw,
  output logic signed [ebgc_pkg::OUT_W-1:0] res
);
  import ebgc_pkg::*;

  // Item registers.
  logic [RAW_W-1:0]        raw_q;
  logic                    filt_q;
  logic [EST_W-1:0]        est_q;
  logic signed [OUT_W-1:0] x_q;
  logic signed [OUT_W-1:0] hp_q;
  logic signed [36:0]      lpa_q;

  // Filter state.
  logic signed [OUT_W-1:0] hp_last_input;
  logic signed [OUT_W-1:0] hp_last_output;
  logic signed [OUT_W-1:0] lp_last_output;

  logic [EST_PROD_W-1:0]   est_prod;
  logic [NUM_W-1:0]        num;
  logic [NUM_W-1:0]        chk;
  logic [NUM_W-1:0]        rem;
  logic [EST_W-1:0]        volts;
  logic signed [EST_W:0]   x_wide;
  logic signed [OUT_W-1:0] x_next;
  logic signed [OUT_W+1:0] d;
  logic signed [38:0]      hp_acc;
  logic signed [OUT_W-1:0] hp_next;
  logic signed [36:0]      lpa_next;
  logic signed [37:0]      lp_acc;
  logic signed [OUT_W-1:0] lp_next;

  // The reciprocal estimate never exceeds the exact quotient and is at most one short.
  assign est_prod = EST_PROD_W'(raw) * EST_PROD_W'(CFIX)
                  + EST_PROD_W'(64'd1 << (EST_SHIFT - 1));

  always_comb begin
    num    = ((NUM_W'(raw_q) * NUM_W'(SCALE_NUM)) << FRAC_BITS) + NUM_W'(DIV_HALF);
    chk    = NUM_W'(est_q) * NUM_W'(DIV_DEN);
    rem    = num - chk;
    volts  = est_q + EST_W'(rem >= NUM_W'(DIV_DEN));
    x_wide = $signed({1'b0, volts}) - MID_S;
    x_next = sat20(SAT_IN_W'(x_wide));
  end

  always_comb begin
    d        = (OUT_W + 2)'(hp_last_output) + (OUT_W + 2)'(x_q)
             - (OUT_W + 2)'(hp_last_input);
    hp_acc   = 39'(d) * 39'(HP_ALPHA_S) + 39'sd32768;
    hp_next  = sat20(SAT_IN_W'(hp_acc >>> COEF_SHIFT));
    lpa_next = 37'(lp_last_output) * 37'(LP_ALPHA_S);
    lp_acc   = 38'(lpa_q) + 38'(hp_q) * 38'(LP_BETA_S) + 38'(RND_HALF);
    lp_next  = sat20(SAT_IN_W'(lp_acc >>> COEF_SHIFT));
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      raw_q  <= raw;
      filt_q <= ctl.filt;
      est_q  <= est_prod[EST_SHIFT +: EST_W];
    end
    if (ctl.step_ctr) begin
      x_q <= x_next;
    end
    if (ctl.step_hp) begin
      hp_q  <= hp_next;
      lpa_q <= lpa_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      hp_last_input  <= '0;
      hp_last_output <= '0;
      lp_last_output <= '0;
    end else begin
      if (ctl.step_hp && filt_q == MODE_FILTER) begin
        hp_last_input  <= x_q;
        hp_last_output <= hp_next;
      end
      if (ctl.step_lp && filt_q == MODE_FILTER) begin
        lp_last_output <= lp_next;
      end
    end
  end

  assign res = (filt_q == MODE_FILTER) ? lp_next : $signed({8'b0, raw_q});

endmodule

/* src/emg_bandpass_gap_counter_core.sv */
// Top level: EMG eight-lane band-pass cascade with packet sequence gap counting.
//
//   Channel   Direction  Handshake            Payload
//   sample    in         sample_valid/stall   ebgc_pkg::sample_t (action, seq, 8 raw counts)
//   result    out        result_valid/stall   ebgc_pkg::result_t (8 outputs, gap total)
//   cfg       in         cfg_valid/ready      cfg_data, the filter_mode bit
//
// A sample row passes four steps: the accept edge computes the reciprocal estimate of
// the volts scaling, then the exact centering correction, the high-pass multiply and
// the low-pass multiply-accumulate in every lane, the last held while the output is full.
// A restart transaction produces no result.
// Reset (rst, synchronous) clears all filter and sequence state and sets filter_mode.
// A stall on the result side holds the last stage; the next row is taken once the
// finished row has moved into the output register.
module emg_bandpass_gap_counter_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  ebgc_pkg::sample_t   sample,
  output logic                result_valid,
  input  logic                result_stall,
  output ebgc_pkg::result_t   result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);
  import ebgc_pkg::*;

  // One-hot sequencer stepping all lanes together.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CTR  = 4'b0010,
    ST_HP   = 4'b0100,
    ST_LP   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic filter_mode;
  logic accept;
  logic fire;

  lane_ctl_t lane_ctl;
  seq_ctl_t  seq_ctl;

  logic [RAW_W-1:0]        raw [NCH_MAX];
  logic signed [OUT_W-1:0] res [NCH_MAX];
  logic [GAP_W-1:0]        gap_count;

  // Always writable; config writes must arrive only while idle; the block does not check.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= MODE_FILTER;
    end else if (cfg_valid && cfg_ready) begin
      filter_mode <= cfg_data;
    end
  end

  // New rows are taken only while the lanes are free.
  assign sample_stall = (state != ST_IDLE);
  assign accept       = sample_valid && !sample_stall;

  // The last stage moves into the output register when that register is free or draining.
  assign fire = (state == ST_LP) && (!result_valid || !result_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && sample.action == ACT_ROW) begin
          state_next = ST_CTR;
        end
      end
      ST_CTR: begin
        state_next = ST_HP;
      end
      ST_HP: begin
        state_next = ST_LP;
      end
      ST_LP: begin
        if (fire) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    lane_ctl.restart  = accept && sample.action == ACT_RESTART;
    lane_ctl.start    = accept && sample.action == ACT_ROW;
    lane_ctl.filt     = filter_mode;
    lane_ctl.step_ctr = (state == ST_CTR);
    lane_ctl.step_hp  = (state == ST_HP);
    lane_ctl.step_lp  = fire;

    seq_ctl.restart      = lane_ctl.restart;
    seq_ctl.row          = lane_ctl.start;
    seq_ctl.packet_first = sample.packet_first;
    seq_ctl.seq_num      = sample.seq_num;
  end

  always_comb begin
    raw[0] = sample.ch0;
    raw[1] = sample.ch1;
    raw[2] = sample.ch2;
    raw[3] = sample.ch3;
    raw[4] = sample.ch4;
    raw[5] = sample.ch5;
    raw[6] = sample.ch6;
    raw[7] = sample.ch7;
  end

  // One lane per active channel; channels beyond the configured count read as zero.
  for (genvar c = 0; c < NCH_MAX; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      ebgc_lane u_lane (
        .clk (clk),
        .rst (rst),
        .ctl (lane_ctl),
        .raw (raw[c]),
        .res (res[c])
      );
    end else begin : g_off
      assign res[c] = '0;
    end
  end

  ebgc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .ctl       (seq_ctl),
    .gap_count (gap_count)
  );

  // Merge stage: lane results and the gap total land together in the output register.
  always_ff @(posedge clk) begin
    if (fire) begin
      result.out0      <= res[0];
      result.out1      <= res[1];
      result.out2      <= res[2];
      result.out3      <= res[3];
      result.out4      <= res[4];
      result.out5      <= res[5];
      result.out6      <= res[6];
      result.out7      <= res[7];
      result.gap_total <= gap_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // A new result only ever appears right after the low-pass stage.
  a_result_from_lp: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_LP))
    else $error("result appeared without a low-pass step");

  // A sample row always starts the centering step on the next cycle.
  a_row_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && sample.action == ACT_ROW) |=> (state == ST_CTR))
    else $error("accepted row did not start the lanes");

  // A restart produces no result and leaves the sequencer idle.
  a_restart_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && sample.action == ACT_RESTART) |=> (state == ST_IDLE))
    else $error("restart left the sequencer busy");

  // A full, stalled output register holds the finished row in the last stage.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LP && result_valid && result_stall) |=> (state == ST_LP))
    else $error("last stage advanced into a full output register");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the EMG band-pass cascade and packet gap counter core.
module testbench;
  import ebgc_pkg::*;

  // Q16 constants of the volts conversion and of the two one-pole filters.
  localparam longint MID_VOLTS = (165 * 65536 + 50) / 100;
  localparam longint HP_GAIN   = 61664;
  localparam longint LP_GAIN   = 49283;
  localparam longint LP_FEED   = 65536 - 49283;
  localparam longint CLIP_HI   = 524287;
  localparam longint CLIP_LO   = -524288;

  // Length of the long receiver hold-off that backs the block up into its input.
  localparam int HOLD_CYCLES = 300;
  localparam int ITEMS_PER_SEGMENT = 110;

  // Tracks the filter and sequence state of the block and holds the rows it still owes.
  class row_board;
    logic signed [OUT_W-1:0] hp_in [NCH_MAX];
    logic signed [OUT_W-1:0] hp_out [NCH_MAX];
    logic signed [OUT_W-1:0] lp_out [NCH_MAX];
    logic [SEQ_W-1:0] last_seq;
    bit seeded;
    logic [GAP_W-1:0] gap;
    logic mode;
    result_t pending_rows[$];
    int errors;

    function new();
      clear();
      mode = MODE_FILTER;
      errors = 0;
    endfunction

    function void clear();
      for (int i = 0; i < NCH_MAX; i++) begin
        hp_in[i] = '0;
        hp_out[i] = '0;
        lp_out[i] = '0;
      end
      last_seq = '0;
      seeded = 1'b0;
      gap = '0;
    endfunction

    function longint clip20(longint v);
      if (v > CLIP_HI) return CLIP_HI;
      if (v < CLIP_LO) return CLIP_LO;
      return v;
    endfunction

    // Divide by 2^16 with halves going toward plus infinity.
    function longint round_q16(longint v);
      return (v + 32768) >>> 16;
    endfunction

    function longint to_volts(logic [RAW_W-1:0] raw);
      longint volts;
      volts = (longint'(raw) * 33 * 65536 + 20475) / 40950;
      return clip20(volts - MID_VOLTS);
    endfunction

    function longint filter_lane(int i, longint x);
      longint hp;
      longint lp;
      hp = clip20(round_q16(HP_GAIN * (longint'(hp_out[i]) + x - longint'(hp_in[i]))));
      hp_in[i] = OUT_W'(x);
      hp_out[i] = OUT_W'(hp);
      lp = clip20(round_q16(LP_GAIN * longint'(lp_out[i]) + LP_FEED * hp));
      lp_out[i] = OUT_W'(lp);
      return lp;
    endfunction

    // Called for every accepted sample transaction.
    function void note_input(sample_t s);
      logic [RAW_W-1:0] raw [NCH_MAX];
      longint lane [NCH_MAX];
      logic [SEQ_W-1:0] jump;
      result_t r;
      raw = '{s.ch0, s.ch1, s.ch2, s.ch3, s.ch4, s.ch5, s.ch6, s.ch7};
      if (s.action == ACT_RESTART) begin
        clear();
        return;
      end
      if (s.packet_first) begin
        jump = s.seq_num - last_seq - 8'd1;
        if (seeded) gap += jump;
        last_seq = s.seq_num;
        seeded = 1'b1;
      end
      for (int i = 0; i < NCH_MAX; i++) begin
        if (i >= CHANNELS) lane[i] = 0;
        else if (mode == MODE_FILTER) lane[i] = filter_lane(i, to_volts(raw[i]));
        else lane[i] = longint'(raw[i]);
      end
      r.out0 = OUT_W'(lane[0]);
      r.out1 = OUT_W'(lane[1]);
      r.out2 = OUT_W'(lane[2]);
      r.out3 = OUT_W'(lane[3]);
      r.out4 = OUT_W'(lane[4]);
      r.out5 = OUT_W'(lane[5]);
      r.out6 = OUT_W'(lane[6]);
      r.out7 = OUT_W'(lane[7]);
      r.gap_total = gap;
      pending_rows.push_back(r);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // Called for every accepted result transaction.
    function void check_result(result_t got);
      result_t want;
      if (pending_rows.size() == 0) begin
        $error("result transaction with no row outstanding");
        errors++;
        return;
      end
      want = pending_rows.pop_front();
      compare_field("out0", want.out0, got.out0);
      compare_field("out1", want.out1, got.out1);
      compare_field("out2", want.out2, got.out2);
      compare_field("out3", want.out3, got.out3);
      compare_field("out4", want.out4, got.out4);
      compare_field("out5", want.out5, got.out5);
      compare_field("out6", want.out6, got.out6);
      compare_field("out7", want.out7, got.out7);
      compare_field("gap_total", want.gap_total, got.gap_total);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  sample_t sample = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  // Idle rates in percent of cycles for the sender and the receiver.
  int send_idle_pct = 0;
  int stall_pct = 0;

  // The main process bumps hold_reqs; the stall process answers each bump with one
  // long hold-off that it counts down on its own.
  int unsigned hold_reqs = 0;
  int unsigned hold_done = 0;
  int hold_left = 0;

  logic [SEQ_W-1:0] next_seq = '0;
  row_board board = new();

  emg_bandpass_gap_counter_core dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver stall pattern. A pending hold-off request takes priority over the
  // random stalls and keeps the result side blocked for one long hold-off.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_reqs) begin
      result_stall <= 1'b1;
      hold_done <= hold_reqs;
      hold_left <= HOLD_CYCLES;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result monitor. Values are read at the edge before any update of that edge lands,
  // so the accept condition matches what the block itself sees.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) board.check_result(result);
  end

  // Offers one transaction after a random idle gap and returns at the edge that takes it.
  task automatic send_row(input sample_t s);
    int gap_cycles;
    gap_cycles = 0;
    while (gap_cycles < 40 && $urandom_range(99) < send_idle_pct) gap_cycles++;
    if (gap_cycles > 0) begin
      sample_valid <= 1'b0;
      repeat (gap_cycles) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (sample_stall);
    board.note_input(s);
  endtask

  // Drops valid and waits until every owed row has come back. A restart produces no
  // result, so an extra wait lets the block finish it before anything else happens.
  task automatic settle();
    sample_valid <= 1'b0;
    while (board.pending_rows.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Writes the filter mode register; only called with the block idle.
  task automatic write_mode(input logic m);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.mode = m;
  endtask

  // Even channels get lo, odd channels get hi.
  function automatic sample_t make_row(logic first, logic [SEQ_W-1:0] seq,
                                       logic [RAW_W-1:0] lo, logic [RAW_W-1:0] hi);
    sample_t s;
    s.action = ACT_ROW;
    s.packet_first = first;
    s.seq_num = seq;
    s.ch0 = lo;
    s.ch1 = hi;
    s.ch2 = lo;
    s.ch3 = hi;
    s.ch4 = lo;
    s.ch5 = hi;
    s.ch6 = lo;
    s.ch7 = hi;
    return s;
  endfunction

  // A restart carries random content in the fields that it ignores.
  function automatic sample_t make_restart();
    sample_t s;
    s = sample_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    s.action = ACT_RESTART;
    return s;
  endfunction

  // Mostly full-range counts, with extra weight on the rails and on mid-scale.
  function automatic logic [RAW_W-1:0] pick_count();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return RAW_W'($urandom_range(2049, 2047));
      default: return RAW_W'($urandom());
    endcase
  endfunction

  function automatic sample_t make_random_row(logic first, logic [SEQ_W-1:0] seq);
    sample_t s;
    s.action = ACT_ROW;
    s.packet_first = first;
    s.seq_num = seq;
    s.ch0 = pick_count();
    s.ch1 = pick_count();
    s.ch2 = pick_count();
    s.ch3 = pick_count();
    s.ch4 = pick_count();
    s.ch5 = pick_count();
    s.ch6 = pick_count();
    s.ch7 = pick_count();
    return s;
  endfunction

  // Sends packets: a start row with a sequence number that usually follows on from the
  // last one, then a few more rows with noise in their ignored sequence field. Some
  // packets skip numbers or jump anywhere, some lose their start flag, and a few
  // restarts are mixed in.
  task automatic run_packets(input int n_items);
    int sent;
    int rows;
    int roll;
    logic [SEQ_W-1:0] seq;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        send_row(make_restart());
        sent++;
      end else begin
        if (roll < 80) seq = next_seq;
        else if (roll < 92) seq = next_seq + SEQ_W'($urandom_range(20, 1));
        else seq = SEQ_W'($urandom());
        next_seq = seq + 8'd1;
        rows = $urandom_range(5, 1);
        for (int k = 0; k < rows; k++) begin
          send_row(make_random_row(k == 0 && roll % 17 != 0,
                                   k == 0 ? seq : SEQ_W'($urandom())));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, filter mode out of reset. Rail-to-rail steps give the largest
    // high-pass swings; the sequence numbers walk through a normal step, a skip, a
    // backward step, a wrap through 255 and a repeated number.
    send_row(make_row(1'b1, 8'd0, 12'd0, 12'd0));
    send_row(make_row(1'b1, 8'd1, 12'd4095, 12'd4095));
    send_row(make_row(1'b0, 8'd9, 12'd0, 12'd4095));
    send_row(make_row(1'b1, 8'd5, 12'd4095, 12'd0));
    send_row(make_row(1'b1, 8'd4, 12'd2048, 12'd2047));
    send_row(make_row(1'b1, 8'd255, 12'hAAA, 12'h555));
    send_row(make_row(1'b1, 8'd0, 12'h555, 12'hAAA));
    send_row(make_row(1'b1, 8'd0, 12'd0, 12'd4095));
    // Restart clears the filters and the sequence seed, so the next start row only seeds.
    send_row(make_restart());
    send_row(make_row(1'b0, 8'd3, 12'd4095, 12'd0));
    send_row(make_row(1'b1, 8'd77, 12'd0, 12'd0));
    send_row(make_row(1'b1, 8'd80, 12'd4095, 12'd4095));
    send_row(make_row(1'b1, 8'd81, 12'd0, 12'd0));
    // Raw mode passes counts through and still counts gaps.
    write_mode(MODE_RAW);
    send_row(make_row(1'b1, 8'd82, 12'd0, 12'd4095));
    send_row(make_row(1'b1, 8'd90, 12'd4095, 12'd0));
    send_row(make_row(1'b0, 8'd0, 12'hAAA, 12'h555));
    send_row(make_restart());
    send_row(make_row(1'b1, 8'd10, 12'd1, 12'd4094));
    send_row(make_row(1'b1, 8'd12, 12'd2048, 12'd2047));
    // Back to filtering: the filter state must have been left alone in raw mode.
    write_mode(MODE_FILTER);
    send_row(make_row(1'b1, 8'd13, 12'd4095, 12'd4095));
    send_row(make_row(1'b1, 8'd14, 12'd0, 12'd0));
    send_row(make_row(1'b0, 8'd14, 12'd4095, 12'd0));
    send_row(make_restart());
    next_seq = 8'd15;

    // Random part in four idle phases: none, sender idle, receiver stalling, both.
    // Each phase runs a filter, a raw and a random-mode segment; the first and third
    // phases open with a long receiver hold-off so that the block backs up into its input.
    for (int phase = 0; phase < 4; phase++) begin
      for (int seg = 0; seg < 3; seg++) begin
        if (seg == 0) write_mode(MODE_FILTER);
        else if (seg == 1) write_mode(MODE_RAW);
        else write_mode($urandom_range(99) < 70 ? MODE_FILTER : MODE_RAW);
        send_idle_pct = (phase == 1) ? 53 : (phase == 3) ? 14 : 0;
        stall_pct <= (phase == 2) ? 53 : (phase == 3) ? 14 : 0;
        if (seg == 0 && (phase == 0 || phase == 2)) hold_reqs <= hold_reqs + 1;
        run_packets(ITEMS_PER_SEGMENT);
      end
    end

    settle();
    if (board.errors == 0 && board.pending_rows.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

/* sim.f */
src/ebgc_pkg.sv
src/ebgc_seq.sv
src/ebgc_lane.sv
src/emg_bandpass_gap_counter_core.sv
tb/testbench.sv
